@@ hdl/lzss_decompressor_core_defines.svh @@
// ----------------------------------------------------------------------------
// LZSS decompressor assertion macros
// Shared concurrent-assertion shorthands; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LZSS_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZSS_DECOMPRESSOR_CORE_DEFINES_SVH

// Same-cycle implication
`define LZSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LZSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lzss_pkg.sv @@
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Fixed constants shared by the decoder core and the history ring.
// ----------------------------------------------------------------------------
package lzss_pkg;

  // Data byte width
  localparam int BYTE_W = 8;

  // Ring fill value below the start write position
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

  // Literal field length in bits
  localparam int LITERAL_BITS = 8;

  // Token phases
  typedef logic [1:0] phase_t;
  localparam phase_t PH_FLAG     = 2'd0;
  localparam phase_t PH_LITERAL  = 2'd1;
  localparam phase_t PH_POSITION = 2'd2;
  localparam phase_t PH_LENGTH   = 2'd3;

endpackage

@@ hdl/lzss_ring.sv @@
// ----------------------------------------------------------------------------
// LZSS history ring
// Single-write, single-read byte memory with registered read data and a
// clearing pass after reset that loads the initial fill pattern.
// ----------------------------------------------------------------------------
module lzss_ring
  import lzss_pkg::*;
#(
  parameter int WINDOW_BITS = 10,
  parameter int LENGTH_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   busy,
  input  logic [WINDOW_BITS-1:0] rd_addr,
  output logic [BYTE_W-1:0]      rd_data,
  input  logic                   wr_en,
  input  logic [WINDOW_BITS-1:0] wr_addr,
  input  logic [BYTE_W-1:0]      wr_data
);

  localparam int DEPTH       = 1 << WINDOW_BITS;
  localparam int WRITE_START = DEPTH - (1 << LENGTH_BITS) - 1;

  logic [BYTE_W-1:0]      mem [DEPTH];
  logic [WINDOW_BITS-1:0] clr_idx_r;
  logic                   busy_r;
  logic [BYTE_W-1:0]      rd_data_r;
  logic [BYTE_W-1:0]      clr_val;

  // fill pattern: spaces below the start position, zero at and above it
  assign clr_val = (clr_idx_r < WINDOW_BITS'(WRITE_START)) ? FILL_BYTE : '0;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (&clr_idx_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // memory array: sweep writes take priority over decoder writes
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= clr_val;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign busy    = busy_r;
  assign rd_data = rd_data_r;

endmodule

@@ hdl/lzss_decompressor_core.sv @@
// ----------------------------------------------------------------------------
// LZSS decompressor core
// Bit-serial token decoder with a history ring and byte-at-a-time copy.
// ----------------------------------------------------------------------------
// Each compressed byte is taken in the idle state and then decoded one bit
// per cycle by a small sequencer, pausing while a token's output is emitted;
// no new input byte is taken until all its bits are decoded. A literal token
// emits one byte from the output register, held through any output stall. A
// match emits (length code + 2) bytes copied from the history ring; each copied
// byte passes through the read, load and output request states plus any output
// stall, and ring writes land before the next read, so overlapping copies
// repeat fresh bytes.
// After reset the ring is loaded by a clearing pass during which no input
// is taken.
// ----------------------------------------------------------------------------
`include "lzss_decompressor_core_defines.svh"

module lzss_decompressor_core
  import lzss_pkg::*;
#(
  parameter int WINDOW_BITS = 10,
  parameter int LENGTH_BITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] code_byte
  // output stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic              out_tlast   // last_of_run
);

  localparam int DEPTH       = 1 << WINDOW_BITS;
  localparam int WRITE_START = DEPTH - (1 << LENGTH_BITS) - 1;
  localparam int FW          = (WINDOW_BITS > LITERAL_BITS) ? WINDOW_BITS : LITERAL_BITS;
  localparam int GW          = $clog2(FW + 1);

  localparam logic [GW-1:0] GATH_LIT = GW'(LITERAL_BITS);
  localparam logic [GW-1:0] GATH_POS = GW'(WINDOW_BITS);
  localparam logic [GW-1:0] GATH_LEN = GW'(LENGTH_BITS);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BITS = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [BYTE_W-1:0]      code_r, code_nxt;
  logic [3:0]             bits_left_r, bits_left_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [GW-1:0]          gath_r, gath_nxt;
  logic [FW-1:0]          field_r, field_nxt;
  logic [WINDOW_BITS-1:0] src_r, src_nxt;
  logic [WINDOW_BITS-1:0] wp_r, wp_nxt;
  logic [LENGTH_BITS:0]   copy_left_r, copy_left_nxt;
  logic [BYTE_W-1:0]      out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   ring_busy;
  logic [BYTE_W-1:0]      ring_rd_data;
  logic                   in_fire;
  logic                   out_fire;
  logic                   cur_bit;
  logic [FW-1:0]          field_sh;
  logic [GW-1:0]          gath_inc;

  // history ring
  lzss_ring #(
    .WINDOW_BITS(WINDOW_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (ring_busy),
    .rd_addr(src_r),
    .rd_data(ring_rd_data),
    .wr_en  (out_fire),
    .wr_addr(wp_r),
    .wr_data(out_data_r)
  );

  // handshakes
  assign in_tready = (state_r == S_IDLE) && !ring_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // shared bit shifter
  assign cur_bit  = code_r[BYTE_W-1];
  assign field_sh = {field_r[FW-2:0], cur_bit};
  assign gath_inc = gath_r + 1'b1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    bits_left_nxt = bits_left_r;
    phase_nxt     = phase_r;
    gath_nxt      = gath_r;
    field_nxt     = field_r;
    src_nxt       = src_r;
    wp_nxt        = wp_r;
    copy_left_nxt = copy_left_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          code_nxt      = in_tdata;
          bits_left_nxt = 4'd8;
          state_nxt     = S_BITS;
        end
      end

      S_BITS: begin
        code_nxt      = {code_r[BYTE_W-2:0], 1'b0};
        bits_left_nxt = bits_left_r - 1'b1;
        state_nxt     = (bits_left_r == 4'd1) ? S_IDLE : S_BITS;
        case (phase_r)
          PH_FLAG: begin
            phase_nxt = cur_bit ? PH_LITERAL : PH_POSITION;
            gath_nxt  = '0;
            field_nxt = '0;
          end
          PH_LITERAL: begin
            field_nxt = field_sh;
            gath_nxt  = gath_inc;
            if (gath_inc == GATH_LIT) begin
              out_data_nxt  = field_sh[BYTE_W-1:0];
              out_last_nxt  = 1'b1;
              out_valid_nxt = 1'b1;
              copy_left_nxt = '0;
              phase_nxt     = PH_FLAG;
              gath_nxt      = '0;
              field_nxt     = '0;
              state_nxt     = S_EMIT;
            end
          end
          PH_POSITION: begin
            field_nxt = field_sh;
            gath_nxt  = gath_inc;
            if (gath_inc == GATH_POS) begin
              src_nxt   = field_sh[WINDOW_BITS-1:0];
              phase_nxt = PH_LENGTH;
              gath_nxt  = '0;
              field_nxt = '0;
            end
          end
          PH_LENGTH: begin
            field_nxt = field_sh;
            gath_nxt  = gath_inc;
            if (gath_inc == GATH_LEN) begin
              // bytes still to go after the first one: length code + 1
              copy_left_nxt = {1'b0, field_sh[LENGTH_BITS-1:0]} + 1'b1;
              phase_nxt     = PH_FLAG;
              gath_nxt      = '0;
              field_nxt     = '0;
              state_nxt     = S_READ;
            end
          end
          default: begin
            phase_nxt = PH_FLAG;
          end
        endcase
      end

      // ring read address is src_r; data registers at the end of this cycle
      S_READ: begin
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        out_data_nxt  = ring_rd_data;
        out_last_nxt  = (copy_left_r == '0);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT;
      end

      // output request; the ring write happens on acceptance
      S_EMIT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          wp_nxt        = wp_r + 1'b1;
          if (copy_left_r != '0) begin
            copy_left_nxt = copy_left_r - 1'b1;
            src_nxt       = src_r + 1'b1;
            state_nxt     = S_READ;
          end else if (bits_left_r == 4'd0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_BITS;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bits_left_r <= '0;
      phase_r     <= PH_FLAG;
      gath_r      <= '0;
      field_r     <= '0;
      src_r       <= '0;
      wp_r        <= WINDOW_BITS'(WRITE_START);
      copy_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_left_r <= bits_left_nxt;
      phase_r     <= phase_nxt;
      gath_r      <= gath_nxt;
      field_r     <= field_nxt;
      src_r       <= src_nxt;
      wp_r        <= wp_nxt;
      copy_left_r <= copy_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  `LZSS_ASSERT_IMP(a_ready_no_pending, in_tready, !out_valid_r, "input taken with result pending")
  `LZSS_ASSERT_NXT(a_accept_starts_bits, in_fire, (state_r == S_BITS) && (bits_left_r == 4'd8), "input request did not start bit decoding")
  `LZSS_ASSERT_NXT(a_copy_continues, out_fire && !out_last_r, state_r == S_READ, "copy stopped before its last byte")
  `LZSS_ASSERT_NXT(a_wp_advances, out_fire, wp_r == $past(wp_r) + 1'b1, "write position did not advance on output request")

endmodule
